// ----- hw/rtl/mct_pkg.sv -----
// shared types and constants for the multiband colour threshold block
// no dependencies; imported by the top level and its three submodules

package mct_pkg;

  localparam int MaxBands     = 4;
  localparam int ChannelBits  = 8;
  localparam int NumChannels  = 3;
  localparam int PixBits      = 8;
  localparam int BoundsBits   = 48;
  localparam int CountBits    = 3;
  localparam int CfgIndexBits = 3;

  // configuration register indexes
  typedef enum logic [CfgIndexBits-1:0] {
    REG_BAND_COUNT = 3'd0,
    REG_BAND0      = 3'd1,
    REG_BAND1      = 3'd2,
    REG_BAND2      = 3'd3,
    REG_BAND3      = 3'd4
  } cfg_reg_t;

  typedef logic [NumChannels-1:0][PixBits-1:0] pixel_t;

  // packed so that lows sit in the low half of the register, channel 0 lowest
  typedef struct packed {
    logic [NumChannels-1:0][ChannelBits-1:0] hi;
    logic [NumChannels-1:0][ChannelBits-1:0] lo;
  } bounds_t;

  // per-band compare flags, one bit per channel
  typedef struct packed {
    logic [NumChannels-1:0] flip;
    logic [NumChannels-1:0] ge_lo;
    logic [NumChannels-1:0] le_hi;
  } band_cmp_t;

endpackage

// ----- hw/rtl/multiband_color_threshold_core.sv -----
// multiband colour threshold: top level with input stage and the two work stages
// depends on mct_pkg, mct_cfg_regs, mct_compare, mct_combine
//
// Usage:
//   in_*  : one pixel item per handshake (chan_a, chan_b, chan_c, 8 bits each)
//   out_* : one mask bit per pixel, 1 when the pixel lies in any enabled band
//   cfg_* : register writes, index 0 band count, 1..4 packed bounds of bands 0..3;
//           cfg_ready is always high; writes must be made only while no item is
//           in flight, and the block itself does not enforce this.
//   An accepted item passes three registers in order (input register, compare
//   register, combine/output register) before out_valid rises. One item per
//   cycle is sustained while out_ready stays high; each stage loads whenever it
//   is empty or its item moves on. When the receiver holds out_ready low the
//   result stays on the port and the stages behind it keep filling; in_ready
//   falls only once all three hold items. Reset (rst_n low, synchronous)
//   empties the pipeline and clears the band count and all bounds to zero, so
//   the mask reads 0 until bands are enabled.

module multiband_color_threshold_core #(
  parameter int MAX_BANDS = mct_pkg::MaxBands
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [mct_pkg::PixBits-1:0]       in_chan_a,
  input  logic [mct_pkg::PixBits-1:0]       in_chan_b,
  input  logic [mct_pkg::PixBits-1:0]       in_chan_c,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic                              out_in_band,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [mct_pkg::CfgIndexBits-1:0]  cfg_index,
  input  logic [mct_pkg::BoundsBits-1:0]    cfg_data
);
  import mct_pkg::*;

  logic                 s1_vld_r;
  pixel_t               s1_pix_r;
  logic                 s1_ready;
  logic                 s2_vld;
  logic                 s2_ready;
  band_cmp_t            s2_cmp [MAX_BANDS];
  logic [MAX_BANDS-1:0] band_en;
  bounds_t              bounds [MAX_BANDS];

  mct_cfg_regs #(.MAX_BANDS(MAX_BANDS)) u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .band_en   (band_en),
    .bounds    (bounds)
  );

  // input stage
  assign in_ready = !s1_vld_r || s1_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (in_ready) begin
      s1_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_pix_r <= {in_chan_c, in_chan_b, in_chan_a};
    end
  end

  mct_compare #(.MAX_BANDS(MAX_BANDS)) u_compare (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (s1_vld_r),
    .up_ready (s1_ready),
    .up_pixel (s1_pix_r),
    .bounds   (bounds),
    .dn_valid (s2_vld),
    .dn_ready (s2_ready),
    .dn_cmp   (s2_cmp)
  );

  mct_combine #(.MAX_BANDS(MAX_BANDS)) u_combine (
    .clk         (clk),
    .rst_n       (rst_n),
    .up_valid    (s2_vld),
    .up_ready    (s2_ready),
    .up_cmp      (s2_cmp),
    .band_en     (band_en),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_in_band (out_in_band)
  );

endmodule

// ----- hw/rtl/mct_cfg_regs.sv -----
// configuration register file: band enables and packed band bounds
// depends on mct_pkg

module mct_cfg_regs #(
  parameter int MAX_BANDS = mct_pkg::MaxBands
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [mct_pkg::CfgIndexBits-1:0]  cfg_index,
  input  logic [mct_pkg::BoundsBits-1:0]    cfg_data,
  output logic [MAX_BANDS-1:0]              band_en,
  output mct_pkg::bounds_t                  bounds [MAX_BANDS]
);
  import mct_pkg::*;

  logic [MAX_BANDS-1:0] band_en_r;
  logic [MAX_BANDS-1:0] band_en_nxt;
  bounds_t              bounds_r   [MAX_BANDS];
  bounds_t              bounds_nxt [MAX_BANDS];

  assign cfg_ready = 1'b1;

  // a count above the band total saturates, so each enable is a plain compare
  always_comb begin
    band_en_nxt = band_en_r;
    if (cfg_valid && cfg_index == REG_BAND_COUNT) begin
      for (int i = 0; i < MAX_BANDS; i++) begin
        band_en_nxt[i] = cfg_data[CountBits-1:0] > CountBits'(i);
      end
    end
  end

  always_comb begin
    for (int i = 0; i < MAX_BANDS; i++) begin
      bounds_nxt[i] = bounds_r[i];
      if (cfg_valid && cfg_index == CfgIndexBits'(REG_BAND0) + CfgIndexBits'(i)) begin
        bounds_nxt[i] = bounds_t'(cfg_data);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      band_en_r <= '0;
      for (int i = 0; i < MAX_BANDS; i++) begin
        bounds_r[i] <= '0;
      end
    end else begin
      band_en_r <= band_en_nxt;
      for (int i = 0; i < MAX_BANDS; i++) begin
        bounds_r[i] <= bounds_nxt[i];
      end
    end
  end

  assign band_en = band_en_r;
  always_comb begin
    for (int i = 0; i < MAX_BANDS; i++) begin
      bounds[i] = bounds_r[i];
    end
  end

endmodule

// ----- hw/rtl/mct_compare.sv -----
// compare stage: per band and channel bound compares, registered
// depends on mct_pkg

module mct_compare #(
  parameter int MAX_BANDS = mct_pkg::MaxBands
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  up_valid,
  output logic                  up_ready,
  input  mct_pkg::pixel_t       up_pixel,
  input  mct_pkg::bounds_t      bounds [MAX_BANDS],
  output logic                  dn_valid,
  input  logic                  dn_ready,
  output mct_pkg::band_cmp_t    dn_cmp [MAX_BANDS]
);
  import mct_pkg::*;

  logic      vld_r;
  band_cmp_t cmp_r   [MAX_BANDS];
  band_cmp_t cmp_nxt [MAX_BANDS];

  always_comb begin
    for (int b = 0; b < MAX_BANDS; b++) begin
      for (int k = 0; k < NumChannels; k++) begin
        cmp_nxt[b].flip[k]  = bounds[b].lo[k] > bounds[b].hi[k];
        cmp_nxt[b].ge_lo[k] = ChannelBits'(up_pixel[k]) >= bounds[b].lo[k];
        cmp_nxt[b].le_hi[k] = ChannelBits'(up_pixel[k]) <= bounds[b].hi[k];
      end
    end
  end

  assign up_ready = !vld_r || dn_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (up_ready) begin
      vld_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      for (int b = 0; b < MAX_BANDS; b++) begin
        cmp_r[b] <= cmp_nxt[b];
      end
    end
  end

  assign dn_valid = vld_r;
  always_comb begin
    for (int b = 0; b < MAX_BANDS; b++) begin
      dn_cmp[b] = cmp_r[b];
    end
  end

endmodule

// ----- hw/rtl/mct_combine.sv -----
// combine stage: wrapped-range halves per band, OR over enabled bands,
// registered result item; depends on mct_pkg

module mct_combine #(
  parameter int MAX_BANDS = mct_pkg::MaxBands
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  up_valid,
  output logic                  up_ready,
  input  mct_pkg::band_cmp_t    up_cmp [MAX_BANDS],
  input  logic [MAX_BANDS-1:0]  band_en,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic                  out_in_band
);
  import mct_pkg::*;

  logic                 vld_r;
  logic                 hit_r;
  logic                 hit_nxt;
  logic [MAX_BANDS-1:0] band_hit;

  // flipped channels need only one side in each half; others need both
  always_comb begin
    for (int b = 0; b < MAX_BANDS; b++) begin
      band_hit[b] = band_en[b] && (
        (&(up_cmp[b].ge_lo & (up_cmp[b].le_hi | up_cmp[b].flip))) ||
        (&(up_cmp[b].le_hi & (up_cmp[b].ge_lo | up_cmp[b].flip))));
    end
    hit_nxt = |band_hit;
  end

  assign up_ready = !vld_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (up_ready) begin
      vld_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      hit_r <= hit_nxt;
    end
  end

  assign out_valid   = vld_r;
  assign out_in_band = hit_r;

endmodule

// ----- hw/rtl/mct_checker.sv -----
// port-level checks for the multiband colour threshold core, bound to the top
// depends only on the top level's ports

module mct_checker (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic out_in_band,
  input logic cfg_ready
);

  // empty after reset
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("out_valid high after reset");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_in_band))
    else $error("result changed while stalled");

  // input stalls only when the output is stalled
  a_bp_source: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid && !out_ready)
    else $error("in_ready low without output stall");

  // an accepted item reaches the output while out_ready stays high
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) ##1 out_ready ##1 out_ready |=> out_valid)
    else $error("item not delivered after three cycles");

  a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n) cfg_ready)
    else $error("configuration port not ready");

endmodule

bind multiband_color_threshold_core mct_checker u_mct_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_valid),
  .in_ready    (in_ready),
  .out_valid   (out_valid),
  .out_ready   (out_ready),
  .out_in_band (out_in_band),
  .cfg_ready   (cfg_ready)
);

// ----- verif/tb.sv -----
`timescale 1ns / 100ps
// testbench for multiband_color_threshold_core: directed and random pixels under changing
// band settings, each mask bit checked in order against a predictor; needs mct_pkg and the rtl

module tb;
  import mct_pkg::*;

  localparam int ClkHalf         = 5;
  localparam int ItemsPerSetting = 63;
  localparam int SettingsPerMode = 5;
  localparam int FirstSpareReg   = int'(REG_BAND3) + 1;
  localparam int SpareRegs       = (1 << CfgIndexBits) - FirstSpareReg;
  localparam logic [ChannelBits-1:0] ChanMax = '1;

  class threshold_scoreboard;
    logic [CountBits-1:0] band_count;
    bounds_t              band_bounds [MaxBands];
    bit                   in_band_due [$];
    int unsigned          mismatches;

    function new();
      band_count = '0;
      foreach (band_bounds[i]) band_bounds[i] = '0;
      mismatches = 0;
    endfunction

    function void apply_write(logic [CfgIndexBits-1:0] index, logic [BoundsBits-1:0] data);
      case (index)
        REG_BAND_COUNT: band_count = data[CountBits-1:0];
        REG_BAND0, REG_BAND1, REG_BAND2, REG_BAND3:
          band_bounds[int'(index) - int'(REG_BAND0)] = data;
        default: ;  // spare indexes are ignored
      endcase
    endfunction

    // a wrapped channel splits the band into a lower and an upper half
    function bit band_hit(bounds_t b, pixel_t px);
      bit lower_half;
      bit upper_half;
      lower_half = 1'b1;
      upper_half = 1'b1;
      for (int k = 0; k < NumChannels; k++) begin
        if (b.lo[k] > b.hi[k]) begin
          if (px[k] < b.lo[k]) lower_half = 1'b0;
          if (px[k] > b.hi[k]) upper_half = 1'b0;
        end else if (px[k] < b.lo[k] || px[k] > b.hi[k]) begin
          lower_half = 1'b0;
          upper_half = 1'b0;
        end
      end
      return lower_half || upper_half;
    endfunction

    function bit predict_in_band(pixel_t px);
      int active;
      bit hit;
      active = (band_count > MaxBands) ? MaxBands : int'(band_count);
      hit = 1'b0;
      for (int i = 0; i < active; i++) begin
        if (band_hit(band_bounds[i], px)) hit = 1'b1;
      end
      return hit;
    endfunction

    function void note_pixel(pixel_t px);
      in_band_due.push_back(predict_in_band(px));
    endfunction

    function void check_result(logic got);
      bit want;
      if (in_band_due.size() == 0) begin
        $error("in_band: no item outstanding, actual %b", got);
        mismatches++;
      end else begin
        want = in_band_due.pop_front();
        if (got !== want) begin
          $error("in_band: expected %b, actual %b", want, got);
          mismatches++;
        end
      end
    endfunction

    function int pending();
      return in_band_due.size();
    endfunction
  endclass

  logic                    clk         = 1'b0;
  logic                    rst_n       = 1'b0;
  logic                    in_valid    = 1'b0;
  logic [PixBits-1:0]      in_chan_a   = '0;
  logic [PixBits-1:0]      in_chan_b   = '0;
  logic [PixBits-1:0]      in_chan_c   = '0;
  logic                    out_ready   = 1'b0;
  logic                    cfg_valid   = 1'b0;
  logic [CfgIndexBits-1:0] cfg_index   = '0;
  logic [BoundsBits-1:0]   cfg_data    = '0;
  logic                    in_ready;
  logic                    out_valid;
  logic                    out_in_band;
  logic                    cfg_ready;

  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  threshold_scoreboard sb;

  multiband_color_threshold_core DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_chan_a  (in_chan_a),
    .in_chan_b  (in_chan_b),
    .in_chan_c  (in_chan_c),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_in_band(out_in_band),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always begin
    #ClkHalf clk = 1'b1;
    #ClkHalf clk = 1'b0;
  end

  // result side: check on handshake, then pick the next ready level
  initial begin
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && out_ready) sb.check_result(out_in_band);
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  function automatic pixel_t pix(logic [PixBits-1:0] a, logic [PixBits-1:0] b,
                                 logic [PixBits-1:0] c);
    return {c, b, a};
  endfunction

  function automatic bounds_t pack_bounds(
    logic [ChannelBits-1:0] lo_a, logic [ChannelBits-1:0] lo_b, logic [ChannelBits-1:0] lo_c,
    logic [ChannelBits-1:0] hi_a, logic [ChannelBits-1:0] hi_b, logic [ChannelBits-1:0] hi_c);
    bounds_t b;
    b.lo = {lo_c, lo_b, lo_a};
    b.hi = {hi_c, hi_b, hi_a};
    return b;
  endfunction

  function automatic logic [BoundsBits-1:0] random_word();
    logic [63:0] r;
    r = {$urandom, $urandom};
    return r[BoundsBits-1:0];
  endfunction

  function automatic bounds_t random_bounds();
    bounds_t b;
    for (int k = 0; k < NumChannels; k++) begin
      case ($urandom_range(7))
        0: begin b.lo[k] = '0;      b.hi[k] = ChanMax; end
        1: begin b.lo[k] = $urandom_range(ChanMax); b.hi[k] = b.lo[k]; end
        2: begin b.lo[k] = ChanMax; b.hi[k] = '0; end
        default: begin
          b.lo[k] = $urandom_range(ChanMax);
          b.hi[k] = $urandom_range(ChanMax);
        end
      endcase
    end
    return b;
  endfunction

  // most pixels sit on or near the edges of one of the bands
  function automatic pixel_t random_pixel();
    pixel_t  px;
    bounds_t b;
    bit      aimed;
    b = sb.band_bounds[$urandom_range(MaxBands - 1)];
    aimed = ($urandom_range(3) != 0);
    for (int k = 0; k < NumChannels; k++) begin
      case (aimed ? $urandom_range(4) : 5)
        0: px[k] = b.lo[k];
        1: px[k] = b.hi[k];
        2: px[k] = b.lo[k] - 1'b1;
        3: px[k] = b.hi[k] + 1'b1;
        4: px[k] = $urandom_range(b.lo[k], b.hi[k]);
        default: px[k] = $urandom_range(ChanMax);
      endcase
    end
    return px;
  endfunction

  task automatic send_pixel(pixel_t px);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    in_chan_a <= px[0];
    in_chan_b <= px[1];
    in_chan_c <= px[2];
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_pixel(px);
  endtask

  // leaves cfg_valid high so back-to-back writes need no gap
  task automatic write_reg(logic [CfgIndexBits-1:0] index, logic [BoundsBits-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= index;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.apply_write(index, data);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  task automatic directed();
    // straight out of reset no band is enabled
    send_pixel(pix(0, 0, 0));
    send_pixel(pix(ChanMax, ChanMax, ChanMax));
    settle();

    // band 0 still all zero: only black matches
    write_reg(REG_BAND_COUNT, 1);
    cfg_valid <= 1'b0;
    send_pixel(pix(0, 0, 0));
    send_pixel(pix(0, 0, 1));
    send_pixel(pix(1, 0, 0));
    send_pixel(pix(0, 1, 0));
    settle();

    // ordinary band, inclusive edges
    write_reg(REG_BAND0, pack_bounds(10, 20, 30, 40, 50, 60));
    cfg_valid <= 1'b0;
    send_pixel(pix(10, 20, 30));
    send_pixel(pix(40, 50, 60));
    send_pixel(pix(9, 20, 30));
    send_pixel(pix(10, 50, 61));
    send_pixel(pix(41, 35, 45));
    settle();

    // hue wrapped round zero
    write_reg(REG_BAND0, pack_bounds(170, 50, 50, 10, ChanMax, ChanMax));
    cfg_valid <= 1'b0;
    send_pixel(pix(170, 50, 50));
    send_pixel(pix(10, ChanMax, ChanMax));
    send_pixel(pix(169, 60, 60));
    send_pixel(pix(11, 60, 60));
    send_pixel(pix(200, 49, 60));
    settle();

    // oversized count saturates, band 2 wrapped on every channel, spare indexes change nothing
    write_reg(REG_BAND_COUNT, '1);
    write_reg(REG_BAND1, '1);
    write_reg(REG_BAND2, pack_bounds(ChanMax, ChanMax, ChanMax, 0, 0, 0));
    write_reg(REG_BAND3, pack_bounds(100, 100, 100, 110, 110, 110));
    for (int k = 0; k < SpareRegs; k++) write_reg(CfgIndexBits'(FirstSpareReg + k), '1);
    cfg_valid <= 1'b0;
    send_pixel(pix(ChanMax, ChanMax, ChanMax));
    send_pixel(pix(105, 105, 105));
    send_pixel(pix(0, 0, 0));
    send_pixel(pix(128, 0, 0));
    settle();

    write_reg(REG_BAND_COUNT, MaxBands + 1);
    cfg_valid <= 1'b0;
    send_pixel(pix(105, 105, 105));
    settle();
  endtask

  task automatic random_setting(int step);
    logic [BoundsBits-1:0] count_word;
    count_word = random_word();
    case (step)
      0:       count_word[CountBits-1:0] = '0;
      1:       count_word[CountBits-1:0] = MaxBands;
      2:       count_word[CountBits-1:0] = '1;
      default: count_word[CountBits-1:0] = $urandom_range(MaxBands);
    endcase
    write_reg(REG_BAND_COUNT, count_word);
    for (int i = 0; i < MaxBands; i++)
      write_reg(CfgIndexBits'(int'(REG_BAND0) + i), random_bounds());
    if ($urandom_range(1) != 0)
      write_reg(CfgIndexBits'(FirstSpareReg + $urandom_range(SpareRegs - 1)), random_word());
    cfg_valid <= 1'b0;
  endtask

  initial begin
    sb = new();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    directed();
    for (int mode = 0; mode < 3; mode++) begin
      send_idle_pct  = (mode == 0) ? 25 : (mode == 1) ? 70 : 0;
      recv_stall_pct = (mode == 0) ? 70 : (mode == 1) ? 25 : 0;
      for (int s = 0; s < SettingsPerMode; s++) begin
        random_setting(s);
        repeat (ItemsPerSetting) send_pixel(random_pixel());
        settle();
      end
    end
    // wait past the pipeline depth to catch stray results
    repeat (8) @(posedge clk);
    if (sb.mismatches == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

  initial begin
    #(ClkHalf * 2 * 400_000);
    $display("tb failed");
    $finish;
  end

endmodule
